### design/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types and constants for the button press classifier
// ----------------------------------------------------------------------------
package bpc_pkg;

	// sample counter width, the counter wraps at this many bits
	localparam int COUNT_WIDTH = 16;

	// widest configuration register
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 8;

	// compare width: covers both the counter and the widest threshold
	localparam int CMP_W = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;

	// register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TICKS_PER_SAMPLE   = 8'd0,
		REG_DEBOUNCE_SAMPLES   = 8'd1,
		REG_LONG_PRESS_SAMPLES = 8'd2,
		REG_DOUBLE_GAP_SAMPLES = 8'd3
	} reg_index_t;

	// reset values
	localparam logic [7:0]  TICKS_RESET  = 8'd10;
	localparam logic [7:0]  DEBNC_RESET  = 8'd3;
	localparam logic [15:0] LONG_RESET   = 16'd100;
	localparam logic [7:0]  GAP_RESET    = 8'd15;

	// event codes
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SHORT  = 2'd1,
		EV_LONG   = 2'd2,
		EV_DOUBLE = 2'd3
	} event_t;

endpackage

### design/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier
// debounces a raw active-low button and reports short, long and double presses
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   pin_level (1 bit, 0 = pressed)
// output    out        out_valid / out_stall event_code (2 bits)
// config    in         cfg_write             cfg_index, cfg_data
//
// one result transaction per input transaction, one transaction per cycle
// sustained while out_stall is low; each passes the input register, then the result register
// the prescaler, the phase machine and the event code are settled in the one
// logic level between the input register and the result register
// reset (arst_n low) puts the phase at idle, clears the counters and loads
// the register reset values; the first tick after reset runs a step
// a stalled result holds the result register; the input register keeps taking
// a transaction as long as its item can move on in the same cycle
//
module button_press_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              pin_level,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        event_code,
	// configuration write port
	input  logic                              cfg_write,
	input  logic [bpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_CHECK_LONG   = 3'd1,
		PH_GAP          = 3'd2,
		PH_SECOND       = 3'd3,
		PH_WAIT_RELEASE = 3'd4
	} phase_t;

	localparam int CW = bpc_pkg::COUNT_WIDTH;
	localparam int MW = bpc_pkg::CMP_W;

	// configuration registers
	logic [7:0]  ticks_per_sample_q;
	logic [7:0]  debounce_samples_q;
	logic [15:0] long_press_samples_q;
	logic [7:0]  double_gap_samples_q;

	// classifier state
	phase_t      phase_q;
	logic [CW-1:0] sample_count_q;
	logic [7:0]  tick_countdown_q;

	// input register
	logic        valid_s1;
	logic        pin_s1;

	// result register
	logic        out_valid_q;
	bpc_pkg::event_t event_q;

	// next-state logic
	logic        advance;
	logic [7:0]  cd_dec;
	logic        do_step;
	logic        pressed;
	logic [CW-1:0] count_inc;
	logic [MW-1:0] count_inc_ext;
	logic        hit_debounce;
	logic        hit_long;
	logic        hit_gap;
	phase_t      phase_next;
	logic [CW-1:0] count_next;
	logic [7:0]  cd_next;
	bpc_pkg::event_t ev_next;

	// the input register's item moves on when the result register is free or emptying
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	assign out_valid  = out_valid_q;
	assign event_code = event_q;

	// prescaler: a zero reload behaves like a reload of one
	assign cd_dec  = (tick_countdown_q != 8'd0) ? (tick_countdown_q - 8'd1) : 8'd0;
	assign do_step = (cd_dec == 8'd0);

	assign pressed       = !pin_s1;
	assign count_inc     = sample_count_q + {{(CW-1){1'b0}}, 1'b1};
	assign count_inc_ext = MW'(count_inc);

	// equality compares on the wrapped count, thresholds zero-extended
	assign hit_debounce = (count_inc_ext == MW'(debounce_samples_q));
	assign hit_long     = (count_inc_ext == MW'(long_press_samples_q));
	assign hit_gap      = (count_inc_ext == MW'(double_gap_samples_q));

	always_comb begin
		phase_next = phase_q;
		count_next = sample_count_q;
		cd_next    = cd_dec;
		ev_next    = bpc_pkg::EV_NONE;
		if (do_step) begin
			cd_next = ticks_per_sample_q;
			unique case (phase_q)
				PH_CHECK_LONG: begin
					if (pressed) begin
						count_next = count_inc;
						if (hit_long) begin
							phase_next = PH_WAIT_RELEASE;
							ev_next    = bpc_pkg::EV_LONG;
						end
					end else begin
						phase_next = PH_GAP;
						count_next = '0;
					end
				end
				PH_GAP: begin
					count_next = count_inc;
					if (pressed) begin
						phase_next = PH_SECOND;
						count_next = '0;
					end else if (hit_gap) begin
						phase_next = PH_IDLE;
						count_next = '0;
						ev_next    = bpc_pkg::EV_SHORT;
					end
				end
				PH_SECOND: begin
					if (pressed) begin
						count_next = count_inc;
						if (hit_debounce) begin
							phase_next = PH_WAIT_RELEASE;
							ev_next    = bpc_pkg::EV_DOUBLE;
						end
					end else begin
						phase_next = PH_IDLE;
						count_next = '0;
						ev_next    = bpc_pkg::EV_SHORT;
					end
				end
				PH_WAIT_RELEASE: begin
					if (!pressed) begin
						phase_next = PH_IDLE;
						count_next = '0;
					end
				end
				default: begin
					// idle, and any unused code falls back to idle
					phase_next = PH_IDLE;
					if (pressed) begin
						count_next = count_inc;
						if (hit_debounce) begin
							phase_next = PH_CHECK_LONG;
						end
					end else begin
						count_next = '0;
					end
				end
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_sample_q   <= bpc_pkg::TICKS_RESET;
			debounce_samples_q   <= bpc_pkg::DEBNC_RESET;
			long_press_samples_q <= bpc_pkg::LONG_RESET;
			double_gap_samples_q <= bpc_pkg::GAP_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bpc_pkg::REG_TICKS_PER_SAMPLE:   ticks_per_sample_q   <= cfg_data[7:0];
				bpc_pkg::REG_DEBOUNCE_SAMPLES:   debounce_samples_q   <= cfg_data[7:0];
				bpc_pkg::REG_LONG_PRESS_SAMPLES: long_press_samples_q <= cfg_data[15:0];
				bpc_pkg::REG_DOUBLE_GAP_SAMPLES: double_gap_samples_q <= cfg_data[7:0];
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// input register, classifier state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			out_valid_q      <= 1'b0;
			phase_q          <= PH_IDLE;
			sample_count_q   <= '0;
			tick_countdown_q <= 8'd0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q      <= 1'b1;
				phase_q          <= phase_next;
				sample_count_q   <= count_next;
				tick_countdown_q <= cd_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			pin_s1 <= pin_level;
		end
		if (advance) begin
			event_q <= ev_next;
		end
	end

`ifndef ASSERT_OFF
	// an event is only reported on a step, which reloads the prescaler
	a_event_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ev_next != bpc_pkg::EV_NONE)
		|=> (tick_countdown_q == $past(ticks_per_sample_q)))
		else $error("event reported without a prescaler reload");

	// long and double presses always wait for the release
	a_wait_after_press: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (ev_next == bpc_pkg::EV_LONG || ev_next == bpc_pkg::EV_DOUBLE))
		|=> (phase_q == PH_WAIT_RELEASE))
		else $error("long or double press not followed by wait for release");

	// a taken result with nothing behind it empties the result register
	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !valid_s1) |=> !out_valid_q)
		else $error("result repeated after it was taken");

	// a short press always ends in idle with a cleared count
	a_short_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ev_next == bpc_pkg::EV_SHORT)
		|=> (phase_q == PH_IDLE && sample_count_q == '0))
		else $error("short press did not return to idle");
`endif

endmodule
